[src/rpn_pkg.sv]
package rpn_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_B,
        ST_RD_A,
        ST_EXEC,
        ST_ITER,
        ST_FIN,
        ST_END_RD,
        ST_END
    } state_t;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_OPER = 2'd1;
    localparam logic [1:0] REQ_END  = 2'd2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_FEW   = 3'd1;
    localparam logic [2:0] STAT_DIV0  = 3'd2;
    localparam logic [2:0] STAT_BADOP = 3'd3;
    localparam logic [2:0] STAT_COUNT = 3'd4;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

endpackage

[src/rpn_ram.sv]
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/rpn_stack_evaluator_core.sv]
// A number item, an ignored item or an end item that reports an error is handled while idle.
// An end item with one value left goes through ST_END_RD and ST_END; add and subtract go
// through ST_RD_B, ST_RD_A and ST_EXEC; multiply and divide then run 32 steps of the shared
// shift/add unit and ST_FIN. Power repeats that multiply per exponent step, up to 31 steps.
// One item is in work at a time; in_ready is high only while the sequencer is idle.
// Reset (rst_n, asynchronous, active low) empties the stack and clears error and flags.
module rpn_stack_evaluator_core #(
    parameter int STACK_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] value,
    input  logic [2:0]  op_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_value,
    output logic [2:0]  status,
    output logic        saturated,
    output logic        push_dropped
);

    import rpn_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    // Sequencer and expression state.
    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [2:0]     err_reg, err_next;
    logic           sat_reg, sat_next;
    logic           drop_reg, drop_next;
    logic [2:0]     op_reg, op_next;

    // Operand and shared unit registers. For multiply, acc_lo holds the
    // multiplier and the low product half; for divide it holds the dividend
    // and collects the quotient while acc_hi holds the partial remainder.
    logic [31:0]    b_reg, b_next;
    logic [31:0]    acc_hi_reg, acc_hi_next;
    logic [31:0]    acc_lo_reg, acc_lo_next;
    logic [31:0]    mcand_reg, mcand_next;
    logic [4:0]     step_reg, step_next;
    logic [4:0]     pw_exp_reg, pw_exp_next;
    logic           neg_reg, neg_next;

    // Output register.
    logic           ovld_reg, ovld_next;
    logic [31:0]    ores_reg, ores_next;
    logic [2:0]     ostat_reg, ostat_next;
    logic           osat_reg, osat_next;
    logic           odrop_reg, odrop_next;

    // Stack memory ports.
    logic           we;
    logic [AW-1:0]  waddr;
    logic [31:0]    wdata;
    logic [AW-1:0]  raddr;
    logic [31:0]    rdata;

    rpn_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic [CW-1:0]  cnt_m1;
    logic [CW-1:0]  cnt_m2;
    logic           accept;

    // Shared adder: multiply accumulates, divide trial-subtracts.
    logic [33:0]    add_x;
    logic [33:0]    add_y;
    logic           add_cin;
    logic [33:0]    add_sum;
    logic [32:0]    div_x;

    // Operand helpers for the execute step.
    logic [31:0]    a_abs;
    logic [31:0]    b_abs;
    logic [32:0]    addsub;
    logic [63:0]    prod;
    logic           prod_big;
    logic [63:0]    fin_mag;
    logic           fin_cap;

    always_comb
    begin
        cnt_m1 = cnt_reg - ONE_C;
        cnt_m2 = cnt_reg - TWO_C;
        accept = in_valid && in_ready;

        a_abs  = rdata[31] ? (~rdata + 32'd1) : rdata;
        b_abs  = b_reg[31] ? (~b_reg + 32'd1) : b_reg;
        addsub = (op_reg == OP_SUB) ? ({rdata[31], rdata} - {b_reg[31], b_reg})
                                    : ({rdata[31], rdata} + {b_reg[31], b_reg});

        div_x = {acc_hi_reg, acc_lo_reg[31]};
        if (op_reg == OP_DIV)
        begin
            add_x   = {1'b0, div_x};
            add_y   = ~{2'b00, mcand_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_x   = {2'b00, acc_hi_reg};
            add_y   = acc_lo_reg[0] ? {2'b00, mcand_reg} : 34'd0;
            add_cin = 1'b0;
        end
        add_sum = add_x + add_y + {33'd0, add_cin};

        prod     = {acc_hi_reg, acc_lo_reg};
        prod_big = (|prod[63:32]) || (prod[31] && (|prod[30:0]));
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        sat_next    = sat_reg;
        drop_next   = drop_reg;
        op_next     = op_reg;
        b_next      = b_reg;
        acc_hi_next = acc_hi_reg;
        acc_lo_next = acc_lo_reg;
        mcand_next  = mcand_reg;
        step_next   = step_reg;
        pw_exp_next = pw_exp_reg;
        neg_next    = neg_reg;
        ovld_next   = ovld_reg && !out_ready;
        ores_next   = ores_reg;
        ostat_next  = ostat_reg;
        osat_next   = osat_reg;
        odrop_next  = odrop_reg;
        we          = 1'b0;
        waddr       = cnt_m2[AW-1:0];
        wdata       = 32'd0;
        raddr       = '0;
        fin_mag     = 64'd0;
        fin_cap     = 1'b0;

        // A new item is taken only while idle, and an end item also needs
        // the output register to be free.
        in_ready = (state_reg == ST_IDLE) && (!ovld_reg || (req_type != REQ_END));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_PUSH:
                        begin
                            if (err_reg == STAT_OK)
                            begin
                                if (cnt_reg == DEPTH_C)
                                begin
                                    drop_next = 1'b1;
                                end
                                else
                                begin
                                    we       = 1'b1;
                                    waddr    = cnt_reg[AW-1:0];
                                    wdata    = value;
                                    cnt_next = cnt_reg + ONE_C;
                                end
                            end
                        end
                        REQ_OPER:
                        begin
                            if (err_reg == STAT_OK)
                            begin
                                if (cnt_reg < TWO_C)
                                begin
                                    err_next = STAT_FEW;
                                end
                                else
                                begin
                                    op_next    = op_code;
                                    state_next = ST_RD_B;
                                end
                            end
                        end
                        REQ_END:
                        begin
                            if (err_reg == STAT_OK && cnt_reg == ONE_C)
                            begin
                                state_next = ST_END_RD;
                            end
                            else
                            begin
                                ovld_next  = 1'b1;
                                ores_next  = 32'd0;
                                ostat_next = (err_reg != STAT_OK) ? err_reg : STAT_COUNT;
                                osat_next  = sat_reg;
                                odrop_next = drop_reg;
                                cnt_next   = '0;
                                err_next   = STAT_OK;
                                sat_next   = 1'b0;
                                drop_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD_B:
            begin
                raddr      = cnt_m1[AW-1:0];
                state_next = ST_RD_A;
            end
            ST_RD_A:
            begin
                raddr      = cnt_m2[AW-1:0];
                b_next     = rdata;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // rdata now holds the lower operand a.
                state_next  = ST_IDLE;
                acc_hi_next = 32'd0;
                acc_lo_next = a_abs;
                mcand_next  = b_abs;
                step_next   = 5'd0;
                neg_next    = rdata[31] ^ b_reg[31];
                case (op_reg) inside
                    OP_ADD, OP_SUB:
                    begin
                        we       = 1'b1;
                        cnt_next = cnt_m1;
                        if (addsub[32] != addsub[31])
                        begin
                            sat_next = 1'b1;
                            wdata    = addsub[32] ? S32_MIN : S32_MAX;
                        end
                        else
                        begin
                            wdata = addsub[31:0];
                        end
                    end
                    OP_MUL:
                    begin
                        state_next = ST_ITER;
                    end
                    OP_DIV:
                    begin
                        if (b_reg == 32'd0)
                        begin
                            err_next = STAT_DIV0;
                            cnt_next = cnt_m2;
                        end
                        else
                        begin
                            state_next = ST_ITER;
                        end
                    end
                    OP_POW:
                    begin
                        we       = 1'b1;
                        cnt_next = cnt_m1;
                        if (b_reg == 32'd0)
                        begin
                            wdata = 32'd1;
                        end
                        else if (rdata == 32'd1)
                        begin
                            wdata = 32'd1;
                        end
                        else if (rdata == 32'hFFFF_FFFF)
                        begin
                            wdata = b_reg[0] ? 32'hFFFF_FFFF : 32'd1;
                        end
                        else if (b_reg[31])
                        begin
                            // Negative exponent: the fraction truncates to zero,
                            // except that zero to a negative power overflows.
                            if (rdata == 32'd0)
                            begin
                                sat_next = 1'b1;
                                wdata    = S32_MAX;
                            end
                            else
                            begin
                                wdata = 32'd0;
                            end
                        end
                        else if (rdata == 32'd0)
                        begin
                            wdata = 32'd0;
                        end
                        else if (|b_reg[30:5])
                        begin
                            // Any base of magnitude two or more overflows here.
                            sat_next = 1'b1;
                            wdata    = (rdata[31] && b_reg[0]) ? S32_MIN : S32_MAX;
                        end
                        else
                        begin
                            // General case: repeated multiply, starting from one.
                            we          = 1'b0;
                            cnt_next    = cnt_reg;
                            acc_lo_next = 32'd1;
                            mcand_next  = a_abs;
                            pw_exp_next = b_reg[4:0];
                            neg_next    = rdata[31] && b_reg[0];
                            state_next  = ST_ITER;
                        end
                    end
                    default:
                    begin
                        err_next = STAT_BADOP;
                        cnt_next = cnt_m2;
                    end
                endcase
            end
            ST_ITER:
            begin
                if (op_reg == OP_DIV)
                begin
                    if (!add_sum[33])
                    begin
                        acc_hi_next = add_sum[31:0];
                    end
                    else
                    begin
                        acc_hi_next = div_x[31:0];
                    end
                    acc_lo_next = {acc_lo_reg[30:0], !add_sum[33]};
                end
                else
                begin
                    acc_hi_next = add_sum[32:1];
                    acc_lo_next = {add_sum[0], acc_lo_reg[31:1]};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                fin_cap = 1'b1;
                if (op_reg == OP_DIV)
                begin
                    fin_mag = {32'd0, acc_lo_reg};
                end
                else if (op_reg == OP_POW)
                begin
                    if (prod_big)
                    begin
                        fin_mag = 64'h0000_0000_8000_0001;
                    end
                    else if (pw_exp_reg != 5'd1)
                    begin
                        // Another factor of the base is still due.
                        fin_cap     = 1'b0;
                        pw_exp_next = pw_exp_reg - 5'd1;
                        acc_hi_next = 32'd0;
                        acc_lo_next = prod[31:0];
                        step_next   = 5'd0;
                        state_next  = ST_ITER;
                    end
                    else
                    begin
                        fin_mag = prod;
                    end
                end
                else
                begin
                    fin_mag = prod;
                end

                if (fin_cap)
                begin
                    we         = 1'b1;
                    cnt_next   = cnt_m1;
                    state_next = ST_IDLE;
                    if (neg_reg)
                    begin
                        if ((|fin_mag[63:32]) || (fin_mag[31] && (|fin_mag[30:0])))
                        begin
                            sat_next = 1'b1;
                            wdata    = S32_MIN;
                        end
                        else
                        begin
                            wdata = ~fin_mag[31:0] + 32'd1;
                        end
                    end
                    else if ((|fin_mag[63:32]) || fin_mag[31])
                    begin
                        sat_next = 1'b1;
                        wdata    = S32_MAX;
                    end
                    else
                    begin
                        wdata = fin_mag[31:0];
                    end
                end
            end
            ST_END_RD:
            begin
                raddr      = '0;
                state_next = ST_END;
            end
            ST_END:
            begin
                ovld_next  = 1'b1;
                ores_next  = rdata;
                ostat_next = STAT_OK;
                osat_next  = sat_reg;
                odrop_next = drop_reg;
                cnt_next   = '0;
                err_next   = STAT_OK;
                sat_next   = 1'b0;
                drop_next  = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            err_reg   <= STAT_OK;
            sat_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            sat_reg   <= sat_next;
            drop_reg  <= drop_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        b_reg      <= b_next;
        acc_hi_reg <= acc_hi_next;
        acc_lo_reg <= acc_lo_next;
        mcand_reg  <= mcand_next;
        step_reg   <= step_next;
        pw_exp_reg <= pw_exp_next;
        neg_reg    <= neg_next;
        ores_reg   <= ores_next;
        ostat_reg  <= ostat_next;
        osat_reg   <= osat_next;
        odrop_reg  <= odrop_next;
    end

    assign out_valid    = ovld_reg;
    assign result_value = ores_reg;
    assign status       = ostat_reg;
    assign saturated    = osat_reg;
    assign push_dropped = odrop_reg;

    // The stack never holds more values than it has entries.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("stack count beyond depth");

    // Operand reads start only with two values on the stack.
    a_two_operands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_B) |-> (cnt_reg >= TWO_C))
        else $error("operator started with too few operands");

    // The shared unit never runs once an error has latched.
    a_iter_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ITER) |-> (err_reg == STAT_OK))
        else $error("iteration with an error latched");

    // A reported error always carries a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovld_reg && ostat_reg != STAT_OK) |-> (ores_reg == 32'd0))
        else $error("nonzero value with error status");

endmodule

[sim/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rpn_pkg::*;

    localparam int DEPTH = 128;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_PUSH;
    logic [31:0] value = '0;
    logic [2:0]  op_code = OP_ADD;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] result_value;
    logic [2:0]  status;
    logic        saturated;
    logic        push_dropped;

    bit tail_phase = 1'b0;
    bit stim_done = 1'b0;

    always #10 clk = ~clk;

    rpn_stack_evaluator_core #(.STACK_DEPTH(DEPTH)) dut (.*);

    typedef struct packed {
        logic [31:0] val;
        logic [2:0]  st;
        logic        sat;
        logic        drop;
    } summary_t;

    // Scoreboard: a private copy of the evaluator's stack and latched flags. Each
    // accepted item updates it; an end item queues the summary the block must report.
    class rpn_scoreboard;
        logic signed [31:0] stk[DEPTH];
        int                 depth_used;
        logic [2:0]         err;
        bit                 sat_seen;
        bit                 drop_seen;
        summary_t           pending[$];
        bit                 failed;

        function new();
            depth_used = 0;
            err = STAT_OK;
            sat_seen = 0;
            drop_seen = 0;
            failed = 0;
        endfunction

        function longint clamp(longint x);
            if (x > 64'sd2147483647) begin
                sat_seen = 1;
                return 64'sd2147483647;
            end
            if (x < -64'sd2147483648) begin
                sat_seen = 1;
                return -64'sd2147483648;
            end
            return x;
        endfunction

        function longint power(longint a, longint b);
            longint mag;
            bit neg;
            if (b == 0) return 1;
            if (b < 0) begin
                if (a == 1) return 1;
                if (a == -1) return b[0] ? -1 : 1;
                if (a == 0) return clamp(64'sd2147483648);
                return 0;
            end
            if (a == 0) return 0;
            if (a == 1) return 1;
            if (a == -1) return b[0] ? -1 : 1;
            neg = (a < 0) && b[0];
            if (b >= 32) return clamp(neg ? -64'sd2147483649 : 64'sd2147483648);
            mag = 1;
            for (longint i = 0; i < b; i++) begin
                mag = mag * (a < 0 ? -a : a);
                if (mag > 64'sd2147483648) begin
                    mag = 64'sd2147483649;
                    break;
                end
            end
            return clamp(neg ? -mag : mag);
        endfunction

        function void push(longint x);
            if (depth_used >= DEPTH) begin
                drop_seen = 1;
                return;
            end
            stk[depth_used] = x[31:0];
            depth_used++;
        endfunction

        function void note_item(logic [1:0] rq, logic signed [31:0] v, logic [2:0] op);
            longint a, b, r;
            summary_t s;
            if (rq == REQ_PUSH) begin
                if (err == STAT_OK) push(v);
            end else if (rq == REQ_OPER) begin
                if (err != STAT_OK) return;
                if (depth_used < 2) begin
                    err = STAT_FEW;
                    return;
                end
                b = stk[depth_used - 1];
                a = stk[depth_used - 2];
                depth_used -= 2;
                case (op)
                    OP_ADD: r = clamp(a + b);
                    OP_SUB: r = clamp(a - b);
                    OP_MUL: r = clamp(a * b);
                    OP_DIV:
                    begin
                        if (b == 0) begin
                            err = STAT_DIV0;
                            return;
                        end
                        r = clamp(a / b);
                    end
                    OP_POW: r = power(a, b);
                    default:
                    begin
                        err = STAT_BADOP;
                        return;
                    end
                endcase
                push(r);
            end else if (rq == REQ_END) begin
                s.val = '0;
                if (err != STAT_OK) s.st = err;
                else if (depth_used != 1) s.st = STAT_COUNT;
                else begin
                    s.st = STAT_OK;
                    s.val = stk[0];
                end
                s.sat = sat_seen;
                s.drop = drop_seen;
                pending.push_back(s);
                depth_used = 0;
                err = STAT_OK;
                sat_seen = 0;
                drop_seen = 0;
            end
        endfunction

        function void check_result(summary_t got);
            summary_t w;
            if (pending.size() == 0) begin
                $error("unexpected result value=%0h status=%0d", got.val, got.st);
                failed = 1;
                return;
            end
            w = pending.pop_front();
            if (got.val !== w.val) begin
                $error("result_value expected %0h actual %0h", w.val, got.val);
                failed = 1;
            end
            if (got.st !== w.st) begin
                $error("status expected %0d actual %0d", w.st, got.st);
                failed = 1;
            end
            if (got.sat !== w.sat) begin
                $error("saturated expected %0b actual %0b", w.sat, got.sat);
                failed = 1;
            end
            if (got.drop !== w.drop) begin
                $error("push_dropped expected %0b actual %0b", w.drop, got.drop);
                failed = 1;
            end
        endfunction
    endclass

    rpn_scoreboard sb = new();

    // Monitor: every accepted input item and every accepted result goes to the
    // scoreboard, sampled at the clock edge where the handshake completes.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) sb.note_item(req_type, value, op_code);
        if (rst_n && out_valid && out_ready)
            sb.check_result({result_value, status, saturated, push_dropped});
    end

    // Result side stalls in random bursts until the final stretch of the run.
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!tail_phase && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 19);
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Present one item and hold it until the block takes it, with an occasional
    // random gap in front of it.
    task automatic send_item(logic [1:0] rq, logic [31:0] v, logic [2:0] op);
        int gap;
        if (!tail_phase && $urandom_range(0, 6) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        value <= v;
        op_code <= op;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic push_num(logic [31:0] v);
        send_item(REQ_PUSH, v, 3'($urandom));
    endtask

    task automatic apply(logic [2:0] op);
        send_item(REQ_OPER, $urandom, op);
    endtask

    task automatic finish_expr();
        send_item(REQ_END, $urandom, 3'($urandom));
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 4)) - 2);
            3: return $urandom;
            4: return 32'($signed($urandom_range(0, 40)) - 20);
            5: return 32'($signed($urandom_range(0, 200000)) - 100000);
            default: return 32'($signed($urandom_range(0, 1000)) - 500);
        endcase
    endfunction

    // Keeps the power exponent small so the slow iterative path stays cheap;
    // once in a while a large or negative exponent is used.
    function automatic logic [31:0] rand_exponent();
        case ($urandom_range(0, 9))
            0: return 32'($signed($urandom_range(0, 6)) - 6);
            1: return 32'($urandom_range(31, 40));
            2: return $urandom;
            default: return 32'($urandom_range(0, 12));
        endcase
    endfunction

    // One well-formed expression: keep the operand count near the number of
    // operators so most of them finish with exactly one value.
    task automatic random_expression(output int used);
        int live, steps;
        logic [2:0] op;
        used = 0;
        live = 0;
        steps = $urandom_range(1, 8);
        for (int i = 0; i < steps; i++) begin
            if (live < 2 || $urandom_range(0, 2) == 0) begin
                push_num(rand_operand());
                live++;
            end else begin
                op = 3'($urandom_range(0, 4));
                if ($urandom_range(0, 40) == 0) op = 3'($urandom_range(5, 7));
                if (op == OP_POW) begin
                    push_num(rand_exponent());
                    used++;
                    live++;
                end
                apply(op);
                live--;
            end
            used++;
        end
        while (live > 1 && $urandom_range(0, 5) != 0) begin
            apply(3'($urandom_range(0, 2)));
            live--;
            used++;
        end
        finish_expr();
        used++;
    endtask

    initial begin
        int count, used;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: operator extremes and a set of special cases.
        push_num(32'h7FFF_FFFF); push_num(32'd1); apply(OP_ADD); finish_expr();
        push_num(32'h8000_0000); push_num(32'd1); apply(OP_SUB); finish_expr();
        push_num(32'h8000_0000); push_num(32'hFFFF_FFFF); apply(OP_DIV); finish_expr();
        push_num(32'd7); push_num(32'd0); apply(OP_DIV); push_num(32'd3); finish_expr();
        push_num(32'd5); apply(OP_MUL); finish_expr();
        push_num(32'd2); push_num(32'd3); send_item(REQ_OPER, '0, 3'd7); finish_expr();
        push_num(32'd0); push_num(32'd0); apply(OP_POW); finish_expr();
        push_num(32'd0); push_num(32'hFFFF_FFFD); apply(OP_POW); finish_expr();
        push_num(32'hFFFF_FFFF); push_num(32'hFFFF_FFFB); apply(OP_POW); finish_expr();
        push_num(32'hFFFF_FFF9); push_num(32'hFFFF_FFFF); apply(OP_POW); finish_expr();
        push_num(32'hFFFF_FFFE); push_num(32'd31); apply(OP_POW); finish_expr();
        send_item(2'd3, $urandom, OP_ADD);
        finish_expr();
        push_num(32'd1); push_num(32'd2); finish_expr();

        // Fill past the top of the stack to exercise dropped pushes.
        for (int i = 0; i < DEPTH + 3; i++) push_num($urandom);
        for (int i = 0; i < DEPTH - 1; i++) apply(OP_ADD);
        finish_expr();

        count = 0;
        while (count < 1440) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(2'($urandom), rand_operand(), 3'($urandom));
                count++;
            end else begin
                random_expression(used);
                count += used;
            end
            if (count > 1200) tail_phase = 1'b1;
        end
        finish_expr();
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (!sb.failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #500ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
